// File: design/rslm_pkg.sv
// Shared types, register codes and constant tables for the recency stack level map.
`default_nettype none

package rslm_pkg;

    localparam int RANK_W      = 5;
    localparam int LEVEL_W     = 16;
    localparam int MODE_W      = 2;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 7;
    localparam int CFG_CNT_W   = 5;
    localparam int PCT_W       = 7;
    localparam int NUM_PCT     = 6;
    localparam int NUM_LEVELS  = 3;
    localparam int DIV_STEPS   = LEVEL_W;
    localparam int DCNT_W      = $clog2(DIV_STEPS + 1);
    localparam int OUT_DATA_W  = ((RANK_W + NUM_LEVELS * LEVEL_W + 7) / 8) * 8;
    localparam int IN_USER_W   = 8;
    localparam int OUT_USER_W  = 8;

    localparam int FULL_LEVEL    = 65535;
    localparam int PCT_SCALE     = 100;
    localparam int PCT_LUT_DEPTH = 2 ** PCT_W;

    localparam logic [MODE_W-1:0] MODE_FOCUS   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DESTROY = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_UNUSED  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_RANK_COUNT   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_START   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OPACITY_LOW  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OPACITY_HIGH = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_LOW   = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_HIGH  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SATUR_LOW    = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SATUR_HIGH   = 4'd7;

    localparam logic [CFG_CNT_W-1:0] RST_RANK_COUNT = 5'd5;
    localparam logic [CFG_CNT_W-1:0] RST_FADE_START = 5'd2;

    typedef logic [PCT_W-1:0] t_pct_regs [NUM_PCT];
    localparam t_pct_regs RST_PCT = '{7'd70, 7'd100, 7'd90, 7'd100, 7'd100, 7'd100};

    typedef logic [PCT_LUT_DEPTH-1:0][LEVEL_W-1:0] t_pct_lut;

    function automatic t_pct_lut build_pct_lut();
        t_pct_lut lut;
        int       p;
        for (int i = 0; i < PCT_LUT_DEPTH; i++) begin
            p = (i > PCT_SCALE) ? PCT_SCALE : i;
            lut[i] = LEVEL_W'((p * FULL_LEVEL) / PCT_SCALE);
        end
        return lut;
    endfunction

    localparam t_pct_lut PCT_LUT = build_pct_lut();

    typedef struct packed {
        logic start;
        logic work;
        logic update;
        logic mult;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic done;
    } t_status;

endpackage

`default_nettype wire

// File: design/rslm_ctrl.sv
// Sequencing state machine for the recency stack level map.
`default_nettype none

module rslm_ctrl
    import rslm_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_s_tvalid,
    output logic         o_s_tready,
    output logic         o_m_tvalid,
    input  wire logic    i_m_tready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_WORK   = 5'b00010,
        ST_UPDATE = 5'b00100,
        ST_MULT   = 5'b01000,
        ST_FIN    = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_ovalid, n_ovalid;

    always_comb begin
        o_cmd        = '0;
        o_cmd.start  = (r_state == ST_IDLE) && i_s_tvalid;
        o_cmd.work   = (r_state == ST_WORK);
        o_cmd.update = (r_state == ST_UPDATE);
        o_cmd.mult   = (r_state == ST_MULT);
        o_cmd.load   = (r_state == ST_FIN) && (!r_ovalid || i_m_tready);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = ST_WORK;
                end
            end
            ST_WORK: begin
                if (i_status.done) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: n_state = ST_MULT;
            ST_MULT:   n_state = ST_FIN;
            ST_FIN: begin
                if (o_cmd.load) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_ovalid = r_ovalid;
        if (o_cmd.load) begin
            n_ovalid = 1'b1;
        end else if (i_m_tready) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_ovalid;

endmodule

`default_nettype wire

// File: design/rslm_dp.sv
// Datapath: configuration registers, id stack, search, step dividers and level map.
`default_nettype none

module rslm_dp
    import rslm_pkg::*;
#(
    parameter int MAX_ENTRIES = 16,
    parameter int ID_BITS     = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cmd                  i_cmd,
    output t_status                    o_status,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic [MODE_W-1:0]     i_mode,
    input  wire logic [ID_BITS-1:0]    i_item_id,
    input  wire logic                  i_eligible,
    input  wire logic [LEVEL_W-1:0]    i_paint [NUM_LEVELS],
    output logic [RANK_W-1:0]          o_rank,
    output logic                       o_found,
    output logic                       o_changed,
    output logic [LEVEL_W-1:0]         o_level [NUM_LEVELS]
);

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CW    = $clog2(MAX_ENTRIES + 1);

    function automatic logic [CW-1:0] clamp_count(logic [CFG_CNT_W-1:0] c);
        logic [CW-1:0] v;
        if (c == '0) begin
            v = CW'(1);
        end else if (int'(c) > MAX_ENTRIES) begin
            v = CW'(MAX_ENTRIES);
        end else begin
            v = CW'(c);
        end
        return v;
    endfunction

    logic [CFG_CNT_W-1:0] r_count_cfg;
    logic [CFG_CNT_W-1:0] r_start_cfg;
    t_pct_regs            r_pct;

    logic [ID_BITS-1:0] r_ids [MAX_ENTRIES];
    logic [ID_BITS-1:0] n_ids [MAX_ENTRIES];

    logic [MODE_W-1:0]  r_mode;
    logic [ID_BITS-1:0] r_id;
    logic               r_elig;
    logic [LEVEL_W-1:0] r_paint [NUM_LEVELS];

    logic [CW-1:0]      r_sidx;
    logic               r_sdone;
    logic [DCNT_W-1:0]  r_dcnt;
    logic [CW-1:0]      r_rem  [NUM_LEVELS];
    logic [LEVEL_W-1:0] r_quo  [NUM_LEVELS];
    logic               r_neg  [NUM_LEVELS];

    logic [CW-1:0]      r_rank;
    logic               r_found;
    logic               r_changed;
    logic [LEVEL_W-1:0] r_prod [NUM_LEVELS];

    logic [CW-1:0]        w_n, w_s, w_d, w_n_new, w_rms, w_pmax;
    logic [CFG_CNT_W-1:0] w_start_m1;
    logic [LEVEL_W-1:0]   w_hi   [NUM_LEVELS];
    logic [LEVEL_W-1:0]   w_lo   [NUM_LEVELS];
    logic [LEVEL_W:0]     w_diff [NUM_LEVELS];
    logic [LEVEL_W-1:0]   w_mag  [NUM_LEVELS];
    logic [LEVEL_W-1:0]   w_step [NUM_LEVELS];
    logic [LEVEL_W-1:0]   w_lvl  [NUM_LEVELS];
    logic [CW:0]          w_rsh  [NUM_LEVELS];
    logic                 w_qbit [NUM_LEVELS];
    logic                 w_cfg_ok, w_match, w_hit, w_focus_go, w_dest_go;

    assign w_n        = clamp_count(r_count_cfg);
    assign w_start_m1 = (r_start_cfg == '0) ? '0 : r_start_cfg - 1'b1;
    assign w_s        = (int'(w_start_m1) >= int'(w_n)) ? w_n - 1'b1 : CW'(w_start_m1);
    assign w_d        = w_n - w_s;

    assign w_cfg_ok   = i_cfg_we && (i_cfg_index <= REG_SATUR_HIGH);
    assign w_n_new    = (i_cfg_index == REG_RANK_COUNT) ?
                        clamp_count(i_cfg_data[CFG_CNT_W-1:0]) : w_n;

    assign w_match    = (r_ids[r_sidx[IDX_W-1:0]] == r_id) && (r_id != '0);
    assign w_hit      = (r_sidx != w_n);
    assign w_focus_go = (r_mode == MODE_FOCUS) && r_elig && (r_id != '0);
    assign w_dest_go  = (r_mode == MODE_DESTROY) && (r_id != '0);
    assign w_pmax     = w_hit ? r_sidx : w_n - 1'b1;
    assign w_rms      = (r_rank >= w_s) ? r_rank - w_s : '0;

    assign o_status.done = r_sdone && (r_dcnt == DCNT_W'(DIV_STEPS));

    always_comb begin
        for (int k = 0; k < NUM_LEVELS; k++) begin
            w_lo[k]   = PCT_LUT[r_pct[2*k]];
            w_hi[k]   = PCT_LUT[r_pct[2*k+1]];
            w_diff[k] = {1'b0, w_hi[k]} - {1'b0, w_lo[k]};
            w_mag[k]  = w_diff[k][LEVEL_W] ? LEVEL_W'(-w_diff[k]) : w_diff[k][LEVEL_W-1:0];
            w_rsh[k]  = {r_rem[k], r_quo[k][LEVEL_W-1]};
            w_qbit[k] = (w_rsh[k] >= {1'b0, w_d});
            w_step[k] = r_neg[k] ? LEVEL_W'(-r_quo[k]) : r_quo[k];
            w_lvl[k]  = w_hi[k] - r_prod[k];
        end
    end

    always_comb begin
        n_ids = r_ids;
        if (w_cfg_ok) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                if (CW'(i) >= w_n_new) begin
                    n_ids[i] = '0;
                end
            end
        end else if (i_cmd.update) begin
            if (w_focus_go && (r_sidx != '0)) begin
                for (int i = 1; i < MAX_ENTRIES; i++) begin
                    if (CW'(i) <= w_pmax) begin
                        n_ids[i] = r_ids[i-1];
                    end
                end
                n_ids[0] = r_id;
            end else if (w_dest_go && w_hit) begin
                for (int i = 0; i < MAX_ENTRIES - 1; i++) begin
                    if ((CW'(i) >= r_sidx) && (CW'(i) < w_n - 1'b1)) begin
                        n_ids[i] = r_ids[i+1];
                    end
                end
                for (int i = 0; i < MAX_ENTRIES; i++) begin
                    if (CW'(i) == w_n - 1'b1) begin
                        n_ids[i] = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count_cfg <= RST_RANK_COUNT;
            r_start_cfg <= RST_FADE_START;
            r_pct       <= RST_PCT;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                r_ids[i] <= '0;
            end
        end else begin
            r_ids <= n_ids;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_RANK_COUNT: r_count_cfg <= i_cfg_data[CFG_CNT_W-1:0];
                    REG_FADE_START: r_start_cfg <= i_cfg_data[CFG_CNT_W-1:0];
                    default: begin
                        if (i_cfg_index inside {[REG_OPACITY_LOW:REG_SATUR_HIGH]}) begin
                            r_pct[3'(i_cfg_index - REG_OPACITY_LOW)] <= i_cfg_data;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sdone <= 1'b0;
            r_dcnt  <= '0;
            r_sidx  <= '0;
        end else if (i_cmd.start) begin
            r_sdone <= 1'b0;
            r_dcnt  <= '0;
            r_sidx  <= '0;
        end else if (i_cmd.work) begin
            if (!r_sdone) begin
                if (!w_hit || w_match) begin
                    r_sdone <= 1'b1;
                end else begin
                    r_sidx <= r_sidx + 1'b1;
                end
            end
            if (r_dcnt != DCNT_W'(DIV_STEPS)) begin
                r_dcnt <= r_dcnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_mode  <= i_mode;
            r_id    <= i_item_id;
            r_elig  <= i_eligible;
            r_paint <= i_paint;
            for (int k = 0; k < NUM_LEVELS; k++) begin
                r_rem[k] <= '0;
                r_quo[k] <= w_mag[k];
                r_neg[k] <= w_diff[k][LEVEL_W];
            end
        end else if (i_cmd.work && (r_dcnt != DCNT_W'(DIV_STEPS))) begin
            for (int k = 0; k < NUM_LEVELS; k++) begin
                r_rem[k] <= w_qbit[k] ? CW'(w_rsh[k] - {1'b0, w_d}) : CW'(w_rsh[k]);
                r_quo[k] <= {r_quo[k][LEVEL_W-2:0], w_qbit[k]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            if (w_focus_go) begin
                r_rank    <= '0;
                r_found   <= 1'b1;
                r_changed <= (r_sidx != '0);
            end else if (w_dest_go) begin
                r_rank    <= w_n;
                r_found   <= 1'b0;
                r_changed <= w_hit;
            end else begin
                r_rank    <= r_sidx;
                r_found   <= w_hit;
                r_changed <= 1'b0;
            end
        end
        if (i_cmd.mult) begin
            for (int k = 0; k < NUM_LEVELS; k++) begin
                r_prod[k] <= LEVEL_W'(w_step[k] * LEVEL_W'(w_rms));
            end
        end
        if (i_cmd.load) begin
            o_rank    <= RANK_W'(r_rank);
            o_found   <= r_found;
            o_changed <= r_changed;
            for (int k = 0; k < NUM_LEVELS; k++) begin
                o_level[k] <= (r_elig && (w_lvl[k] < r_paint[k])) ? w_lvl[k] : r_paint[k];
            end
        end
    end

endmodule

`default_nettype wire

// File: design/recency_stack_level_map_unit.sv
// Top level of the recency stack level map: stream ports, controller and datapath.
//
//   Channel   Direction  Handshake                  Contents
//   s         in         i_s_tvalid / o_s_tready    one focus, destroy or query item
//   m         out        o_m_tvalid / i_m_tready    one result item per input item
//   cfg       in         i_cfg_valid / o_cfg_ready  register index and write data
//
// A new item is accepted only once the previous one has finished its work; the 16-step restoring
// divide and the one-entry-a-cycle stack search run side by side and set the time per item,
// and a stalled result side can hold it longer.
// A finished result waits in the output register while the next item is accepted.
// Synchronous active-low reset empties the stack and loads the register defaults.
// Configuration writes are taken in any cycle.
`default_nettype none

module recency_stack_level_map_unit
    import rslm_pkg::*;
#(
    parameter int MAX_ENTRIES = 16,
    parameter int ID_BITS     = 32
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_s_tvalid,
    output logic                                     o_s_tready,
    // item_id, paint_opacity, paint_bright, paint_satur, zero fill
    input  wire logic [((ID_BITS + 3*LEVEL_W + 7) / 8) * 8 - 1:0] i_s_tdata,
    // mode, eligible, zero fill
    input  wire logic [IN_USER_W-1:0]                i_s_tuser,
    output logic                                     o_m_tvalid,
    input  wire logic                                i_m_tready,
    // rank, out_opacity, out_bright, out_satur, zero fill
    output logic [OUT_DATA_W-1:0]                    o_m_tdata,
    // found, stack_changed, zero fill
    output logic [OUT_USER_W-1:0]                    o_m_tuser,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]                i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]               i_cfg_data
);

    t_cmd               w_cmd;
    t_status            w_status;
    logic [LEVEL_W-1:0] w_paint [NUM_LEVELS];
    logic [LEVEL_W-1:0] w_level [NUM_LEVELS];
    logic [RANK_W-1:0]  w_rank;
    logic               w_found;
    logic               w_changed;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        for (int k = 0; k < NUM_LEVELS; k++) begin
            w_paint[k] = i_s_tdata[ID_BITS + k*LEVEL_W +: LEVEL_W];
        end
    end

    rslm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    rslm_dp #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .ID_BITS     (ID_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_mode      (i_s_tuser[MODE_W-1:0]),
        .i_item_id   (i_s_tdata[ID_BITS-1:0]),
        .i_eligible  (i_s_tuser[MODE_W]),
        .i_paint     (w_paint),
        .o_rank      (w_rank),
        .o_found     (w_found),
        .o_changed   (w_changed),
        .o_level     (w_level)
    );

    assign o_m_tdata = OUT_DATA_W'({w_level[2], w_level[1], w_level[0], w_rank});
    assign o_m_tuser = OUT_USER_W'({w_changed, w_found});

endmodule

`default_nettype wire

// File: design/rslm_chk.sv
// Port-level assertion checker for the recency stack level map, bound to the top level.
`default_nettype none

module rslm_chk #(
    parameter int MAX_ENTRIES = 16
) (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_s_tvalid,
    input wire logic       i_s_tready,
    input wire logic       i_m_tvalid,
    input wire logic       i_m_tready,
    input wire logic [4:0] i_rank,
    input wire logic       i_found
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid)
        else $error("result item dropped while stalled");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && i_s_tready |=> !i_s_tready)
        else $error("second item accepted while one is at work");

    a_found_rank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_found |-> int'(i_rank) < MAX_ENTRIES)
        else $error("found rank beyond the stack depth");

    a_absent_rank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_found |-> i_rank != 5'd0)
        else $error("absent id reported at the top rank");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid)
        else $error("result valid right after reset");

endmodule

bind recency_stack_level_map_unit rslm_chk #(
    .MAX_ENTRIES (MAX_ENTRIES)
) u_rslm_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .i_s_tready (o_s_tready),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_rank     (o_m_tdata[4:0]),
    .i_found    (o_m_tuser[0])
);

`default_nettype wire

// File: dv/testbench.sv
// Self-checking testbench for the recency stack level map unit: directed and random streams.
`timescale 1ns / 1ps

module testbench
    import rslm_pkg::*;
;

    localparam int ID_W      = 32;
    localparam int MAX_N     = 16;
    localparam int IN_DATA_W = ((ID_W + 3 * LEVEL_W + 7) / 8) * 8;
    localparam int POOL_N    = 24;

    localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = 4'd8;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [ID_W-1:0]    id;
        logic               elig;
        logic [LEVEL_W-1:0] paint_opacity;
        logic [LEVEL_W-1:0] paint_bright;
        logic [LEVEL_W-1:0] paint_satur;
    } t_item;

    typedef struct packed {
        logic [RANK_W-1:0]  rank;
        logic               found;
        logic               changed;
        logic [LEVEL_W-1:0] opacity;
        logic [LEVEL_W-1:0] bright;
        logic [LEVEL_W-1:0] satur;
    } t_result;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] val;
    } t_reg_write;

    logic                   i_clk     = 1'b0;
    logic                   i_rst_n   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic [IN_DATA_W-1:0]   s_tdata   = '0;
    logic [IN_USER_W-1:0]   s_tuser   = '0;
    logic                   m_tready  = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   o_s_tready;
    logic                   o_m_tvalid;
    logic [OUT_DATA_W-1:0]  o_m_tdata;
    logic [OUT_USER_W-1:0]  o_m_tuser;
    logic                   o_cfg_ready;

    logic [ID_W-1:0]        mtf_ids [MAX_N];
    logic [CFG_DATA_W-1:0]  reg_shadow [8];
    logic [ID_W-1:0]        id_pool [POOL_N];
    int                     pool_span = POOL_N;
    t_result                expected_results [$];
    t_reg_write             pending_writes [$];
    int                     error_count = 0;
    int                     gap_pct   = 30;
    int                     stall_pct = 69;

    recency_stack_level_map_unit #(
        .MAX_ENTRIES(MAX_N),
        .ID_BITS    (ID_W)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    function automatic int active_count();
        int c;
        c = int'(reg_shadow[REG_RANK_COUNT]);
        if (c < 1) c = 1;
        if (c > MAX_N) c = MAX_N;
        return c;
    endfunction

    function automatic int find_slot(logic [ID_W-1:0] id, int n);
        if (id == '0) return n;
        for (int i = 0; i < n; i++) begin
            if (mtf_ids[i] == id) return i;
        end
        return n;
    endfunction

    function automatic logic [LEVEL_W-1:0] fade_value(logic [LEVEL_W-1:0] paint, logic elig,
                                                      int rank, int n, int s,
                                                      logic [CFG_DATA_W-1:0] lo_pct,
                                                      logic [CFG_DATA_W-1:0] hi_pct);
        int lp;
        int hp;
        int lo;
        int hi;
        int step;
        logic [LEVEL_W-1:0] lvl;
        lp = int'(lo_pct);
        hp = int'(hi_pct);
        if (lp > PCT_SCALE) lp = PCT_SCALE;
        if (hp > PCT_SCALE) hp = PCT_SCALE;
        lo = lp * FULL_LEVEL / PCT_SCALE;
        hi = hp * FULL_LEVEL / PCT_SCALE;
        if (rank < s) begin
            lvl = LEVEL_W'(hi);
        end else begin
            step = (hi - lo) / (n - s);
            lvl = LEVEL_W'(hi - step * (rank - s));
        end
        return (elig && lvl < paint) ? lvl : paint;
    endfunction

    task automatic predict_result(input t_item it);
        int n;
        int s;
        int pos;
        int rank;
        t_result r;
        n = active_count();
        s = int'(reg_shadow[REG_FADE_START]);
        if (s < 1) s = 1;
        s = s - 1;
        if (s >= n) s = n - 1;
        r.changed = 1'b0;
        if (it.mode == MODE_FOCUS && it.elig && it.id != '0) begin
            pos = find_slot(it.id, n);
            if (pos > 0) begin
                if (pos >= n) pos = n - 1;
                for (int i = pos; i > 0; i--) mtf_ids[i] = mtf_ids[i-1];
                mtf_ids[0] = it.id;
                r.changed = 1'b1;
            end
        end else if (it.mode == MODE_DESTROY && it.id != '0) begin
            pos = find_slot(it.id, n);
            if (pos < n) begin
                for (int i = pos + 1; i < n; i++) mtf_ids[i-1] = mtf_ids[i];
                mtf_ids[n-1] = '0;
                r.changed = 1'b1;
            end
        end
        rank      = find_slot(it.id, n);
        r.rank    = RANK_W'(rank);
        r.found   = (rank < n);
        r.opacity = fade_value(it.paint_opacity, it.elig, rank, n, s,
                               reg_shadow[REG_OPACITY_LOW], reg_shadow[REG_OPACITY_HIGH]);
        r.bright  = fade_value(it.paint_bright, it.elig, rank, n, s,
                               reg_shadow[REG_BRIGHT_LOW], reg_shadow[REG_BRIGHT_HIGH]);
        r.satur   = fade_value(it.paint_satur, it.elig, rank, n, s,
                               reg_shadow[REG_SATUR_LOW], reg_shadow[REG_SATUR_HIGH]);
        expected_results.push_back(r);
    endtask

    task automatic send_item(input t_item it, input bit last_of_run);
        while ($urandom_range(0, 99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_DATA_W'({it.paint_satur, it.paint_bright, it.paint_opacity, it.id});
        s_tuser  <= {5'b0, it.elig, it.mode};
        do @(posedge i_clk); while (!o_s_tready);
        predict_result(it);
        if (last_of_run) s_tvalid <= 1'b0;
    endtask

    function automatic void queue_reg_write(logic [CFG_IDX_W-1:0] idx,
                                            logic [CFG_DATA_W-1:0] val);
        pending_writes.push_back('{idx, val});
    endfunction

    task automatic apply_settings();
        t_reg_write w;
        while (expected_results.size() != 0) @(posedge i_clk);
        while (pending_writes.size() != 0) begin
            w = pending_writes.pop_front();
            cfg_valid <= 1'b1;
            cfg_index <= w.idx;
            cfg_data  <= w.val;
            do @(posedge i_clk); while (!o_cfg_ready);
            if (w.idx <= REG_SATUR_HIGH) begin
                if (w.idx == REG_RANK_COUNT || w.idx == REG_FADE_START)
                    reg_shadow[w.idx] = {2'b00, w.val[CFG_CNT_W-1:0]};
                else
                    reg_shadow[w.idx] = w.val;
                for (int i = active_count(); i < MAX_N; i++) mtf_ids[i] = '0;
            end
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic t_item make_item(logic [MODE_W-1:0] mode, logic [ID_W-1:0] id,
                                        logic elig, logic [LEVEL_W-1:0] op,
                                        logic [LEVEL_W-1:0] br, logic [LEVEL_W-1:0] sa);
        t_item it;
        it.mode          = mode;
        it.id            = id;
        it.elig          = elig;
        it.paint_opacity = op;
        it.paint_bright  = br;
        it.paint_satur   = sa;
        return it;
    endfunction

    function automatic logic [LEVEL_W-1:0] random_paint();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return '0;
        if (r < 15) return '1;
        return LEVEL_W'($urandom());
    endfunction

    function automatic t_item random_item();
        t_item it;
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)      it.mode = MODE_FOCUS;
        else if (r < 65) it.mode = MODE_DESTROY;
        else if (r < 95) it.mode = MODE_QUERY;
        else             it.mode = MODE_UNUSED;
        r = $urandom_range(0, 99);
        if (r < 80)      it.id = id_pool[$urandom_range(0, pool_span - 1)];
        else if (r < 90) it.id = $urandom();
        else if (r < 95) it.id = '0;
        else             it.id = '1;
        it.elig          = ($urandom_range(0, 99) < 85);
        it.paint_opacity = random_paint();
        it.paint_bright  = random_paint();
        it.paint_satur   = random_paint();
        return it;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_reg_value(logic [CFG_IDX_W-1:0] idx);
        int r;
        r = $urandom_range(0, 99);
        if (idx == REG_RANK_COUNT || idx == REG_FADE_START) begin
            if (r < 8)  return 7'd0;
            if (r < 16) return 7'd127;
            if (r < 30) return 7'd16;
            if (r < 38) return 7'd1;
            return CFG_DATA_W'($urandom_range(1, 20));
        end
        if (r < 8)  return 7'd0;
        if (r < 16) return 7'd100;
        if (r < 22) return 7'd127;
        return CFG_DATA_W'($urandom_range(0, 100));
    endfunction

    task automatic test_stack_updates();
        t_item q [$];
        q.push_back(make_item(MODE_QUERY,   32'h0000_0000, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        q.push_back(make_item(MODE_FOCUS,   32'h0000_0000, 1'b1, 16'hFFFF, 16'h8000, 16'h0001));
        q.push_back(make_item(MODE_FOCUS,   32'h0000_0001, 1'b0, 16'h1234, 16'hFFFF, 16'hFFFF));
        q.push_back(make_item(MODE_FOCUS,   32'h0000_0001, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        q.push_back(make_item(MODE_FOCUS,   32'h0000_0001, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        q.push_back(make_item(MODE_FOCUS,   32'h8000_0000, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        q.push_back(make_item(MODE_FOCUS,   32'h5555_5555, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        q.push_back(make_item(MODE_FOCUS,   32'hAAAA_AAAA, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        q.push_back(make_item(MODE_FOCUS,   32'h0000_FFFF, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        // The stack is full; the oldest entry falls off the bottom.
        q.push_back(make_item(MODE_FOCUS,   32'hFFFF_0000, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        q.push_back(make_item(MODE_DESTROY, 32'h0000_0001, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        q.push_back(make_item(MODE_DESTROY, 32'h5555_5555, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        q.push_back(make_item(MODE_UNUSED,  32'h0000_FFFF, 1'b1, 16'h0000, 16'h0000, 16'h0000));
        q.push_back(make_item(MODE_QUERY,   32'hFFFF_FFFF, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        foreach (q[i]) send_item(q[i], i == q.size() - 1);
    endtask

    task automatic test_register_extremes();
        t_item q [$];
        // Shrinking the count drops the deeper entries for good.
        queue_reg_write(REG_RANK_COUNT, 7'd2);
        queue_reg_write(REG_RANK_COUNT, 7'd5);
        queue_reg_write(REG_FADE_START, 7'd0);
        apply_settings();
        send_item(make_item(MODE_QUERY, 32'h8000_0000, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b1);

        queue_reg_write(REG_RANK_COUNT,   7'd0);
        queue_reg_write(REG_FADE_START,   7'd127);
        queue_reg_write(REG_OPACITY_LOW,  7'd127);
        queue_reg_write(REG_OPACITY_HIGH, 7'd0);
        queue_reg_write(REG_BRIGHT_LOW,   7'd100);
        queue_reg_write(REG_BRIGHT_HIGH,  7'd0);
        queue_reg_write(REG_SATUR_LOW,    7'd0);
        queue_reg_write(REG_SATUR_HIGH,   7'd127);
        apply_settings();
        q.push_back(make_item(MODE_FOCUS, 32'hAAAA_AAAA, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        q.push_back(make_item(MODE_QUERY, 32'hAAAA_AAAA, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        q.push_back(make_item(MODE_QUERY, 32'h0000_0007, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        foreach (q[i]) send_item(q[i], i == q.size() - 1);

        q.delete();
        queue_reg_write(REG_RANK_COUNT, 7'd127);
        queue_reg_write(REG_FADE_START, 7'd127);
        queue_reg_write(REG_FIRST_UNUSED | 4'd1, 7'd3);
        apply_settings();
        q.push_back(make_item(MODE_FOCUS, 32'h0000_0001, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        q.push_back(make_item(MODE_FOCUS, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        q.push_back(make_item(MODE_QUERY, 32'h0000_0001, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        foreach (q[i]) send_item(q[i], i == q.size() - 1);

        q.delete();
        queue_reg_write(REG_RANK_COUNT, 7'd16);
        queue_reg_write(REG_FADE_START, 7'd1);
        apply_settings();
        q.push_back(make_item(MODE_QUERY, 32'hAAAA_AAAA, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        q.push_back(make_item(MODE_QUERY, 32'h0000_0001, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        foreach (q[i]) send_item(q[i], i == q.size() - 1);
    endtask

    task automatic test_random_traffic();
        for (int i = 0; i < POOL_N; i++) begin
            do id_pool[i] = $urandom(); while (id_pool[i] == '0);
        end
        for (int phase = 0; phase < 3; phase++) begin
            gap_pct   = (phase == 0) ? 30 : (phase == 1) ? 69 : 0;
            stall_pct = (phase == 0) ? 69 : (phase == 1) ? 30 : 0;
            for (int seg = 0; seg < 5; seg++) begin
                for (int r = REG_RANK_COUNT; r <= REG_SATUR_HIGH; r++) begin
                    if ($urandom_range(0, 1) == 0)
                        queue_reg_write(CFG_IDX_W'(r), random_reg_value(CFG_IDX_W'(r)));
                end
                if ($urandom_range(0, 9) == 0)
                    queue_reg_write(REG_FIRST_UNUSED | CFG_IDX_W'($urandom_range(0, 7)),
                                    CFG_DATA_W'($urandom()));
                apply_settings();
                pool_span = active_count() + $urandom_range(1, 6);
                if (pool_span > POOL_N) pool_span = POOL_N;
                for (int k = 0; k < 50; k++) send_item(random_item(), k == 49);
            end
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_result oldest;
        if (i_rst_n && o_m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $error("result item arrived with no expectation waiting");
                error_count++;
            end else begin
                oldest = expected_results.pop_front();
                if (o_m_tdata[4:0] !== oldest.rank) begin
                    $error("rank: expected %0d, actual %0d", oldest.rank, o_m_tdata[4:0]);
                    error_count++;
                end
                if (o_m_tuser[0] !== oldest.found) begin
                    $error("found: expected %0d, actual %0d", oldest.found, o_m_tuser[0]);
                    error_count++;
                end
                if (o_m_tuser[1] !== oldest.changed) begin
                    $error("stack_changed: expected %0d, actual %0d",
                           oldest.changed, o_m_tuser[1]);
                    error_count++;
                end
                if (o_m_tdata[20:5] !== oldest.opacity) begin
                    $error("out_opacity: expected %0d, actual %0d",
                           oldest.opacity, o_m_tdata[20:5]);
                    error_count++;
                end
                if (o_m_tdata[36:21] !== oldest.bright) begin
                    $error("out_bright: expected %0d, actual %0d",
                           oldest.bright, o_m_tdata[36:21]);
                    error_count++;
                end
                if (o_m_tdata[52:37] !== oldest.satur) begin
                    $error("out_satur: expected %0d, actual %0d",
                           oldest.satur, o_m_tdata[52:37]);
                    error_count++;
                end
            end
        end
    end

    initial begin
        foreach (mtf_ids[i]) mtf_ids[i] = '0;
        reg_shadow[REG_RANK_COUNT] = {2'b00, RST_RANK_COUNT};
        reg_shadow[REG_FADE_START] = {2'b00, RST_FADE_START};
        for (int i = 0; i < NUM_PCT; i++) reg_shadow[REG_OPACITY_LOW + i] = RST_PCT[i];
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_stack_updates();
        test_register_extremes();
        test_random_traffic();

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            $error("%0d expected results never arrived", expected_results.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("[recency_stack_level_map_unit] OK");
        end else begin
            $display("[recency_stack_level_map_unit] ERROR");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("[recency_stack_level_map_unit] ERROR");
        $finish;
    end

endmodule
